// File: hw/rtl/fingerprint_cluster_ban_table_core_assert.svh
// assertion macros used by the fingerprint cluster ban table port checker
`ifndef FINGERPRINT_CLUSTER_BAN_TABLE_CORE_ASSERT_SVH
`define FINGERPRINT_CLUSTER_BAN_TABLE_CORE_ASSERT_SVH

// checked only outside reset
`define FCBT_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define FCBT_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hw/rtl/fcbt_pkg.sv
// shared types and constants of the fingerprint cluster ban table
`default_nettype none
package fcbt_pkg;
   localparam int NUM_BUCKETS_DEF = 256;
   localparam int MAX_ADDRS_DEF   = 32;

   localparam logic [31:0] FNV_OFFSET = 32'h811C_9DC5;
   localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;

   localparam logic [5:0] MIN_CLUSTER_RST   = 6'd3;
   localparam logic [5:0] MIN_CLUSTER_FLOOR = 6'd2;

   localparam int REQ_DATA_W = 128;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 112;
   localparam int RSP_USER_W = 2;

   typedef enum logic [1:0] {
      STATUS_IGNORED = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_TRACKED = 2'd2,
      STATUS_BAN     = 2'd3
   } status_type;

   typedef enum logic {
      CSR_ENABLE      = 1'b0,
      CSR_MIN_CLUSTER = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_UPDATE,
      S_FLUSH_RD,
      S_FLUSH_OUT,
      S_RESULT
   } state_type;
endpackage
`default_nettype wire

// File: hw/rtl/fingerprint_cluster_ban_table_core.sv
// top level of the fingerprint cluster ban table
//
// Requests arrive on req_ (key and address in tdata, presence and trust flags
// in tuser); results leave on rsp_ with the status code in tuser and tlast on
// the final result of a request. The user must write registers through csr_
// only while the block is idle; the block does not enforce it. csr_ready is
// always high. One request is worked at a time. A request that is ignored
// goes straight to its result. Otherwise the key is hashed and reduced to a
// bucket index, the bucket table is probed, the stored addresses are read and
// compared, the bucket is written back, and a ban flushes each stored address
// as its own result; the memory steps wait on the registered read of the two
// memories. After reset the bucket table is cleared, one bucket a cycle,
// during which req_tready stays low.
// The result register is separate from the worker: when rsp_tready is low the
// next request is still taken and worked until it has a result to show.
`default_nettype none
module fingerprint_cluster_ban_table_core #(
   parameter int NUM_BUCKETS = fcbt_pkg::NUM_BUCKETS_DEF,
   parameter int MAX_ADDRS   = fcbt_pkg::MAX_ADDRS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // fingerprint_key, source_addr
   input  wire logic [fcbt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // key_present, addr_present, addr_trusted
   input  wire logic [fcbt_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // ban_addr, cluster_size, active_clusters, bans_issued, zero pad bit
   output logic      [fcbt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic      [fcbt_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic                              csr_index,
   input  wire logic [5:0]                        csr_data
);
   import fcbt_pkg::*;

   localparam int IW = $clog2(NUM_BUCKETS);
   localparam int PW = $clog2(NUM_BUCKETS + 1);
   localparam int CW = $clog2(MAX_ADDRS + 1);
   localparam int AW = $clog2(NUM_BUCKETS * MAX_ADDRS);
   localparam int SW = 64 + CW + 2;

   state_type      state_ff, state_in;
   logic           enable_ff, enable_in;
   logic [5:0]     min_ff, min_in;
   logic [63:0]    key_ff, key_in;
   logic [63:0]    addr_ff, addr_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [IW-1:0]  clr_ff, clr_in;
   logic [PW-1:0]  probe_ff, probe_in;
   logic           used_ff, used_in;
   logic           banned_ff, banned_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  scan_ff, scan_in;
   logic [AW-1:0]  base_ff, base_in;
   logic [PW-1:0]  occ_ff, occ_in;
   logic [31:0]    ban_ff, ban_in;
   status_type     res_ff, res_in;

   logic           rsp_valid_ff, rsp_valid_in;
   status_type     rsp_status_ff, rsp_status_in;
   logic [63:0]    rsp_addr_ff, rsp_addr_in;
   logic [5:0]     rsp_size_ff, rsp_size_in;
   logic [8:0]     rsp_occ_ff, rsp_occ_in;
   logic [31:0]    rsp_bans_ff, rsp_bans_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           req_fire, ignored, out_free;
   logic           hash_done;
   logic [IW-1:0]  hash_index;
   logic           slot_we, addr_we;
   logic [IW-1:0]  slot_waddr;
   logic [SW-1:0]  slot_wdata, slot_rdata;
   logic [AW-1:0]  addr_raddr, addr_waddr;
   logic [63:0]    addr_rdata;
   logic           rd_used, rd_banned;
   logic [CW-1:0]  rd_count;
   logic [63:0]    rd_key;
   logic [5:0]     thr;
   logic           flush;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign ignored    = !enable_ff || !req_tuser[0] || !req_tuser[1] || req_tuser[2];
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign {rd_key, rd_count, rd_banned, rd_used} = slot_rdata;
   assign addr_raddr = AW'(base_ff + AW'(scan_ff));
   assign thr        = (min_ff < MIN_CLUSTER_FLOOR) ? MIN_CLUSTER_FLOOR : min_ff;
   assign flush      = !banned_ff && (7'(count_ff) >= 7'(thr));

   fcbt_hash_unit #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (req_fire && !ignored),
      .key   (req_tdata[63:0]),
      .done  (hash_done),
      .index (hash_index)
   );

   fcbt_ram #(
      .WIDTH (SW),
      .DEPTH (NUM_BUCKETS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (idx_ff),
      .rd_data (slot_rdata)
   );

   fcbt_ram #(
      .WIDTH (64),
      .DEPTH (NUM_BUCKETS * MAX_ADDRS)
   ) u_addr_ram (
      .clock   (clock),
      .wr_en   (addr_we),
      .wr_addr (addr_waddr),
      .wr_data (addr_ff),
      .rd_addr (addr_raddr),
      .rd_data (addr_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:     if (clr_ff == IW'(NUM_BUCKETS - 1)) state_in = S_IDLE;
         S_IDLE:      if (req_fire) state_in = ignored ? S_RESULT : S_HASH;
         S_HASH:      if (hash_done) state_in = S_PROBE_RD;
         S_PROBE_RD:  state_in = S_PROBE_CHK;
         S_PROBE_CHK: begin
            if (!rd_used || rd_key == key_ff) begin
               state_in = (rd_used && rd_count == CW'(MAX_ADDRS)) ? S_UPDATE : S_SCAN_RD;
            end else if (probe_ff == PW'(NUM_BUCKETS - 1)) begin
               state_in = S_RESULT;
            end else begin
               state_in = S_PROBE_RD;
            end
         end
         S_SCAN_RD:   state_in = (scan_ff == count_ff) ? S_UPDATE : S_SCAN_CHK;
         S_SCAN_CHK:  state_in = (addr_rdata == addr_ff) ? S_UPDATE : S_SCAN_RD;
         S_UPDATE:    state_in = flush ? S_FLUSH_RD : S_RESULT;
         S_FLUSH_RD:  state_in = S_FLUSH_OUT;
         S_FLUSH_OUT: begin
            if (out_free) state_in = (scan_ff + 1'b1 == count_ff) ? S_IDLE : S_FLUSH_RD;
         end
         S_RESULT:    if (out_free) state_in = S_IDLE;
         default:     state_in = S_CLEAR;
      endcase
   end

   // datapath and outputs
   always_comb begin
      enable_in     = enable_ff;
      min_in        = min_ff;
      key_in        = key_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      clr_in        = clr_ff;
      probe_in      = probe_ff;
      used_in       = used_ff;
      banned_in     = banned_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      base_in       = base_ff;
      occ_in        = occ_ff;
      ban_in        = ban_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_bans_in   = rsp_bans_ff;
      rsp_last_in   = rsp_last_ff;
      slot_we       = 1'b0;
      slot_waddr    = idx_ff;
      slot_wdata    = {key_ff, count_ff, banned_ff, used_ff};
      addr_we       = 1'b0;
      addr_waddr    = AW'(base_ff + AW'(count_ff));

      if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE:      enable_in = csr_data[0];
            CSR_MIN_CLUSTER: min_in    = csr_data;
            default:         enable_in = enable_ff;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            slot_wdata = '0;
            clr_in     = clr_ff + 1'b1;
         end
         S_IDLE: begin
            key_in   = req_tdata[63:0];
            addr_in  = req_tdata[127:64];
            probe_in = '0;
            res_in   = STATUS_IGNORED;
         end
         S_HASH: idx_in = hash_index;
         S_PROBE_CHK: begin
            used_in   = 1'b1;
            banned_in = rd_used && rd_banned;
            count_in  = rd_used ? rd_count : '0;
            scan_in   = '0;
            base_in   = AW'(AW'(idx_ff) * AW'(MAX_ADDRS));
            if (!rd_used) begin
               occ_in = occ_ff + 1'b1;
            end else if (rd_key != key_ff) begin
               // probe the next bucket, wrapping
               res_in   = STATUS_FULL;
               probe_in = probe_ff + 1'b1;
               idx_in   = (idx_ff == IW'(NUM_BUCKETS - 1)) ? '0 : idx_ff + 1'b1;
            end
         end
         S_SCAN_RD: begin
            if (scan_ff == count_ff) begin
               addr_we  = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         S_SCAN_CHK: scan_in = scan_ff + 1'b1;
         S_UPDATE: begin
            slot_we    = 1'b1;
            slot_wdata = {key_ff, count_ff, banned_ff || flush, used_ff};
            scan_in    = '0;
            res_in     = STATUS_TRACKED;
         end
         S_FLUSH_OUT: begin
            if (out_free) begin
               ban_in        = (ban_ff == 32'hFFFF_FFFF) ? ban_ff : ban_ff + 32'd1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_BAN;
               rsp_addr_in   = addr_rdata;
               rsp_size_in   = 6'(count_ff);
               rsp_occ_in    = 9'(occ_ff);
               rsp_bans_in   = ban_in;
               rsp_last_in   = (scan_ff + 1'b1 == count_ff);
               scan_in       = scan_ff + 1'b1;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_ff;
               rsp_addr_in   = '0;
               rsp_size_in   = (res_ff == STATUS_TRACKED) ? 6'(count_ff) : 6'd0;
               rsp_occ_in    = 9'(occ_ff);
               rsp_bans_in   = ban_ff;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
            slot_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         enable_ff    <= 1'b0;
         min_ff       <= MIN_CLUSTER_RST;
         clr_ff       <= '0;
         occ_ff       <= '0;
         ban_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         min_ff       <= min_in;
         clr_ff       <= clr_in;
         occ_ff       <= occ_in;
         ban_ff       <= ban_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff        <= key_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      probe_ff      <= probe_in;
      used_ff       <= used_in;
      banned_ff     <= banned_in;
      count_ff      <= count_in;
      scan_ff       <= scan_in;
      base_ff       <= base_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_bans_ff   <= rsp_bans_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, rsp_bans_ff, rsp_occ_ff, rsp_size_ff, rsp_addr_ff};
endmodule
`default_nettype wire

// File: hw/rtl/fcbt_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module fcbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: hw/rtl/fcbt_hash_unit.sv
// fnv-1a key hash, one byte a cycle, then reciprocal reduction to a bucket index
`default_nettype none
module fcbt_hash_unit #(
   parameter int NUM_BUCKETS = fcbt_pkg::NUM_BUCKETS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [63:0]                    key,
   output logic                                done,
   output logic [$clog2(NUM_BUCKETS)-1:0]      index
);
   import fcbt_pkg::*;

   localparam int          IW        = $clog2(NUM_BUCKETS);
   localparam logic [31:0] NB        = 32'(NUM_BUCKETS);
   // floor(2^32 / buckets), the quotient estimate is low by at most one
   localparam logic [31:0] RECIP     = 32'((64'd1 << 32) / 64'(NUM_BUCKETS));
   localparam logic [3:0]  STEP_QUOT = 4'd8;
   localparam logic [3:0]  STEP_REM  = 4'd9;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [31:0]       h_ff, h_in;
   logic [63:0]       key_ff, key_in;
   logic [31:0]       q_ff, q_in;
   logic [31:0]       r_ff, r_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [63:0]       prod;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      h_in    = h_ff;
      key_in  = key_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      idx_in  = idx_ff;
      prod    = {32'd0, h_ff} * {32'd0, RECIP};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         h_in    = FNV_OFFSET;
         key_in  = key;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff < STEP_QUOT) begin
            h_in   = 32'((h_ff ^ {24'd0, key_ff[7:0]}) * FNV_PRIME);
            key_in = key_ff >> 8;
         end else if (cnt_ff == STEP_QUOT) begin
            q_in = prod[63:32];
         end else if (cnt_ff == STEP_REM) begin
            r_in = h_ff - q_ff * NB;
         end else begin
            idx_in  = (r_ff >= NB) ? IW'(r_ff - NB) : IW'(r_ff);
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      h_ff   <= h_in;
      key_ff <= key_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      idx_ff <= idx_in;
   end

   assign done  = done_ff;
   assign index = idx_ff;
endmodule
`default_nettype wire

// File: hw/rtl/fcbt_checker.sv
// port-level checks of the fingerprint cluster ban table
`default_nettype none
`include "fingerprint_cluster_ban_table_core_assert.svh"
module fcbt_port_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [111:0] rsp_tdata,
   input wire logic [1:0]   rsp_tuser,
   input wire logic         rsp_tlast
);
   import fcbt_pkg::*;

   logic non_ban;

   assign non_ban = rsp_tvalid && (rsp_tuser != STATUS_BAN);

   `FCBT_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped while stalled")
   `FCBT_ASSERT(a_single_last, non_ban |-> rsp_tlast, "non-ban result without last")
   `FCBT_ASSERT(a_addr_zero, non_ban |-> rsp_tdata[63:0] == 64'd0, "address on non-ban result")
   `FCBT_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_tvalid && !req_tready, "busy after reset")
endmodule

bind fingerprint_cluster_ban_table_core fcbt_port_checker u_fcbt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
